// ----- sv/sob_pkg.sv -----
// Shared constants for the sequenced order book core.
package sob_pkg;

    localparam int SEQ_W   = 64;
    localparam int KEY_W   = 64;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 32;
    localparam int LVL_W   = 48;
    localparam int STAT_W  = 3;

    localparam logic [STAT_W-1:0] STAT_APPLIED   = 3'd0;
    localparam logic [STAT_W-1:0] STAT_OLD       = 3'd1;
    localparam logic [STAT_W-1:0] STAT_GAP       = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_COLLISION = 3'd4;
    localparam logic [STAT_W-1:0] STAT_OUTSIDE   = 3'd5;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_DEL = 1'b1;

endpackage

// ----- sv/sob_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module sob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/sob_mod.sv -----
// Order key reduction to a table slot index (key modulo slot count).
module sob_mod #(
    parameter int DIV = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [63:0]              key,
    output logic [$clog2(DIV)-1:0]   rem,
    output logic                     done
);

    localparam int SW = $clog2(DIV);

    // Residue of 2^e modulo DIV, evaluated at elaboration
    function automatic longint pow_mod(input int e);
        longint r;
        r = 1;
        for (int j = 0; j < e; j++)
        begin
            r = (r * 2) % DIV;
        end
        return r;
    endfunction

    generate
        if ((DIV & (DIV - 1)) == 0)
        begin : g_pow2
            logic done_reg;

            // Take the low bits; answer in the cycle after start
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            assign rem  = key[SW-1:0];
            assign done = done_reg;
        end
        else
        begin : g_fold
            localparam int NCH = 8;
            localparam int AW  = SW + 12;
            localparam logic [AW-1:0] DIV_TOP = AW'(DIV) << 11;

            logic [AW-1:0] part [NCH];
            logic [AW-1:0] fold_sum;
            logic [AW-1:0] acc_reg, acc_next;
            logic [AW-1:0] dsh_reg, dsh_next;
            logic [1:0]    cnt_reg;
            logic          busy_reg;
            logic          done_reg;

            // Weight each key byte by the residue of its place value
            for (genvar g = 0; g < NCH; g++)
            begin : g_part
                localparam logic [SW-1:0] RES = SW'(pow_mod(8 * g));
                assign part[g] = AW'(key[8*g +: 8]) * AW'(RES);
            end

            // Add the weighted bytes; the sum stays below DIV << 11
            always_comb
            begin
                fold_sum = '0;
                for (int i = 0; i < NCH; i++)
                begin
                    fold_sum = fold_sum + part[i];
                end
            end

            // Four compare-and-subtract steps per cycle, largest multiple first
            always_comb
            begin
                logic [AW-1:0] t;
                logic [AW-1:0] d;
                t = acc_reg;
                d = dsh_reg;
                for (int i = 0; i < 4; i++)
                begin
                    if (t >= d)
                    begin
                        t = t - d;
                    end
                    d = d >> 1;
                end
                acc_next = t;
                dsh_next = d;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    done_reg <= busy_reg && (cnt_reg == 2'd2);
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= '0;
                    end
                    else if (busy_reg)
                    begin
                        cnt_reg <= cnt_reg + 2'd1;
                        if (cnt_reg == 2'd2)
                        begin
                            busy_reg <= 1'b0;
                        end
                    end
                end
            end

            // Load the folded sum on start, reduce while busy
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    acc_reg <= fold_sum;
                    dsh_reg <= DIV_TOP;
                end
                else if (busy_reg)
                begin
                    acc_reg <= acc_next;
                    dsh_reg <= dsh_next;
                end
            end

            assign rem  = acc_reg[SW-1:0];
            assign done = done_reg;
        end
    endgenerate

endmodule

// ----- sv/sequenced_order_book_core.sv -----
// Top level of the sequenced order book: sequence check, order table, price levels.
//
// Each message is processed one at a time. An old or gapped message offers its result in the
// cycle right after acceptance. An applied message walks: slot index (the low key bits when
// ORDER_SLOTS is a power of two, otherwise the key reduction unit), order table read, price
// level read-modify-write, and then offers its result. The input is ready again in the cycle
// after the result is taken. When a change empties the best bid or best ask level, the level
// memory is scanned for the next nonempty level, with one read state and one check state per
// level visited. After reset a clearing pass zeroes both memories; no message is taken during
// it, configuration writes are. The order table and the level memory each have one read and
// one write port; the level memory holds bid and ask totals side by side.
module sequenced_order_book_core #(
    parameter int ORDER_SLOTS = 4096,
    parameter int PRICE_TICKS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [sob_pkg::SEQ_W-1:0]   sequence_number,
    input  logic                        mode,
    input  logic [sob_pkg::KEY_W-1:0]   order_key,
    input  logic [sob_pkg::PRICE_W-1:0] order_price,
    input  logic [sob_pkg::QTY_W-1:0]   order_quantity,
    input  logic                        buy_side,
    // result items
    output logic        out_valid,
    input  logic        out_ready,
    output logic [sob_pkg::STAT_W-1:0]  status,
    output logic [sob_pkg::PRICE_W-1:0] best_bid_price,
    output logic [sob_pkg::PRICE_W-1:0] best_ask_price,
    output logic                        book_stale
);

    import sob_pkg::*;

    localparam int SW     = $clog2(ORDER_SLOTS);
    localparam int TW     = $clog2(PRICE_TICKS);
    localparam int MAXD   = (ORDER_SLOTS > PRICE_TICKS) ? ORDER_SLOTS : PRICE_TICKS;
    localparam int CW     = $clog2(MAXD + 1);
    localparam int SLOT_W = 1 + 1 + QTY_W + TW + KEY_W;
    localparam int LWORD  = 2 * LVL_W;
    localparam logic [TW-1:0] TOP_OFF = TW'(PRICE_TICKS - 1);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_MOD     = 3'd2;
    localparam logic [2:0] S_SLOT    = 3'd3;
    localparam logic [2:0] S_LVL     = 3'd4;
    localparam logic [2:0] S_SCAN_RD = 3'd5;
    localparam logic [2:0] S_SCAN_CK = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    clr_reg, clr_next;
    logic [SEQ_W-1:0] first_seq_reg;
    logic [SEQ_W-1:0] next_seq_reg, next_seq_next;
    logic [PRICE_W-1:0] base_reg;
    logic             stale_reg, stale_next;
    logic             bid_v_reg, bid_v_next;
    logic [TW-1:0]    bid_off_reg, bid_off_next;
    logic             ask_v_reg, ask_v_next;
    logic [TW-1:0]    ask_off_reg, ask_off_next;
    logic             start_reg;

    // message payload
    logic             del_reg;
    logic [KEY_W-1:0] key_reg;
    logic [QTY_W-1:0] qty_reg, qty_next;
    logic             side_reg, side_next;
    logic [TW-1:0]    off_reg;
    logic             win_reg;
    logic [TW-1:0]    lvl_off_reg, lvl_off_next;
    logic [TW-1:0]    scan_reg, scan_next;
    logic [SW-1:0]    slot_idx_reg;
    logic [STAT_W-1:0] status_reg, status_next;

    // memory ports
    logic              slot_we;
    logic [SW-1:0]     slot_waddr, slot_raddr;
    logic [SLOT_W-1:0] slot_wdata, slot_rdata;
    logic              lvl_we;
    logic [TW-1:0]     lvl_waddr, lvl_raddr;
    logic [LWORD-1:0]  lvl_wdata, lvl_rdata;

    logic [SW-1:0]     mod_rem;
    logic              mod_done;

    // order table word fields
    logic              rd_valid;
    logic              rd_side;
    logic [QTY_W-1:0]  rd_qty;
    logic [TW-1:0]     rd_off;
    logic [KEY_W-1:0]  rd_key;

    logic              cfg_wr;
    logic              accept;
    logic [PRICE_W-1:0] price_diff;
    logic              price_in_win;

    assign {rd_valid, rd_side, rd_qty, rd_off, rd_key} = slot_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[3] ? {32'b0, base_reg} : first_seq_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    assign price_diff   = order_price - base_reg;
    assign price_in_win = (order_price >= base_reg) &&
                          (price_diff < PRICE_W'(PRICE_TICKS));

    sob_mod #(
        .DIV (ORDER_SLOTS)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .key   (key_reg),
        .rem   (mod_rem),
        .done  (mod_done)
    );

    sob_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ORDER_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    sob_ram #(
        .WIDTH (LWORD),
        .DEPTH (PRICE_TICKS)
    ) u_lvl_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .raddr (lvl_raddr),
        .rdata (lvl_rdata)
    );

    // Sequence the message through table, levels and best-price scan
    always_comb
    begin
        logic [LVL_W-1:0] old_tot;
        logic [LVL_W-1:0] new_tot;
        logic [LVL_W-1:0] scan_tot;

        state_next    = state_reg;
        clr_next      = clr_reg;
        next_seq_next = next_seq_reg;
        stale_next    = stale_reg;
        bid_v_next    = bid_v_reg;
        bid_off_next  = bid_off_reg;
        ask_v_next    = ask_v_reg;
        ask_off_next  = ask_off_reg;
        qty_next      = qty_reg;
        side_next     = side_reg;
        lvl_off_next  = lvl_off_reg;
        scan_next     = scan_reg;
        status_next   = status_reg;

        slot_we    = 1'b0;
        slot_waddr = slot_idx_reg;
        slot_wdata = {1'b1, side_reg, qty_reg, off_reg, key_reg};
        slot_raddr = mod_rem;
        lvl_we     = 1'b0;
        lvl_waddr  = lvl_off_reg;
        lvl_wdata  = lvl_rdata;
        lvl_raddr  = scan_reg;

        old_tot  = side_reg ? lvl_rdata[LVL_W-1:0] : lvl_rdata[LWORD-1:LVL_W];
        new_tot  = del_reg ? (old_tot - LVL_W'(qty_reg)) : (old_tot + LVL_W'(qty_reg));
        scan_tot = side_reg ? lvl_rdata[LVL_W-1:0] : lvl_rdata[LWORD-1:LVL_W];

        unique case (state_reg)
            S_CLEAR:
            begin
                // Zero one table entry and one level per cycle
                slot_we    = (clr_reg < CW'(ORDER_SLOTS));
                slot_waddr = clr_reg[SW-1:0];
                slot_wdata = '0;
                lvl_we     = (clr_reg < CW'(PRICE_TICKS));
                lvl_waddr  = clr_reg[TW-1:0];
                lvl_wdata  = '0;
                clr_next   = clr_reg + CW'(1);
                if (clr_reg == CW'(MAXD - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                // Check the sequence number on acceptance
                if (accept)
                begin
                    qty_next  = order_quantity;
                    side_next = buy_side;
                    if (sequence_number < next_seq_reg)
                    begin
                        status_next = STAT_OLD;
                        state_next  = S_OUT;
                    end
                    else if (sequence_number > next_seq_reg)
                    begin
                        status_next = STAT_GAP;
                        stale_next  = 1'b1;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        next_seq_next = next_seq_reg + SEQ_W'(1);
                        state_next    = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                // Read the table entry once the slot index is ready
                if (mod_done)
                begin
                    state_next = S_SLOT;
                end
            end
            S_SLOT:
            begin
                if (del_reg == MODE_ADD)
                begin
                    if (!win_reg)
                    begin
                        status_next = STAT_OUTSIDE;
                        stale_next  = 1'b1;
                        state_next  = S_OUT;
                    end
                    else if (rd_valid)
                    begin
                        status_next = STAT_COLLISION;
                        stale_next  = 1'b1;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        slot_we      = 1'b1;
                        lvl_raddr    = off_reg;
                        lvl_off_next = off_reg;
                        state_next   = S_LVL;
                    end
                end
                else
                begin
                    if (!rd_valid || (rd_key != key_reg))
                    begin
                        status_next = STAT_NOT_FOUND;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        // Drop the order, then take back its quantity
                        slot_we      = 1'b1;
                        slot_wdata   = {1'b0, rd_side, rd_qty, rd_off, rd_key};
                        lvl_raddr    = rd_off;
                        lvl_off_next = rd_off;
                        qty_next     = rd_qty;
                        side_next    = rd_side;
                        state_next   = S_LVL;
                    end
                end
            end
            S_LVL:
            begin
                // Write the new level total and track the best price
                lvl_we      = 1'b1;
                lvl_wdata   = side_reg ? {lvl_rdata[LWORD-1:LVL_W], new_tot}
                                       : {new_tot, lvl_rdata[LVL_W-1:0]};
                status_next = STAT_APPLIED;
                state_next  = S_OUT;
                if (side_reg)
                begin
                    if (new_tot != '0)
                    begin
                        if (!bid_v_reg || (lvl_off_reg > bid_off_reg))
                        begin
                            bid_v_next   = 1'b1;
                            bid_off_next = lvl_off_reg;
                        end
                    end
                    else if (bid_v_reg && (lvl_off_reg == bid_off_reg))
                    begin
                        if (lvl_off_reg == '0)
                        begin
                            bid_v_next = 1'b0;
                        end
                        else
                        begin
                            scan_next  = lvl_off_reg - TW'(1);
                            state_next = S_SCAN_RD;
                        end
                    end
                end
                else
                begin
                    if (new_tot != '0)
                    begin
                        if (!ask_v_reg || (lvl_off_reg < ask_off_reg))
                        begin
                            ask_v_next   = 1'b1;
                            ask_off_next = lvl_off_reg;
                        end
                    end
                    else if (ask_v_reg && (lvl_off_reg == ask_off_reg))
                    begin
                        if (lvl_off_reg == TOP_OFF)
                        begin
                            ask_v_next = 1'b0;
                        end
                        else
                        begin
                            scan_next  = lvl_off_reg + TW'(1);
                            state_next = S_SCAN_RD;
                        end
                    end
                end
            end
            S_SCAN_RD:
            begin
                lvl_raddr  = scan_reg;
                state_next = S_SCAN_CK;
            end
            S_SCAN_CK:
            begin
                // Stop at the first nonempty level, else advance away from the old best
                if (scan_tot != '0)
                begin
                    if (side_reg)
                    begin
                        bid_off_next = scan_reg;
                    end
                    else
                    begin
                        ask_off_next = scan_reg;
                    end
                    state_next = S_OUT;
                end
                else if (side_reg)
                begin
                    if (scan_reg == '0)
                    begin
                        bid_v_next = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        scan_next  = scan_reg - TW'(1);
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    if (scan_reg == TOP_OFF)
                    begin
                        ask_v_next = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        scan_next  = scan_reg + TW'(1);
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Restart the sequence check on a write of the first sequence
        if (cfg_wr && !paddr[3])
        begin
            next_seq_next = pwdata;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            first_seq_reg <= '0;
            next_seq_reg  <= '0;
            base_reg      <= '0;
            stale_reg     <= 1'b0;
            bid_v_reg     <= 1'b0;
            bid_off_reg   <= '0;
            ask_v_reg     <= 1'b0;
            ask_off_reg   <= '0;
            start_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            next_seq_reg <= next_seq_next;
            stale_reg    <= stale_next;
            bid_v_reg    <= bid_v_next;
            bid_off_reg  <= bid_off_next;
            ask_v_reg    <= ask_v_next;
            ask_off_reg  <= ask_off_next;
            start_reg    <= accept && (sequence_number == next_seq_reg);
            if (cfg_wr)
            begin
                if (paddr[3])
                begin
                    base_reg <= pwdata[PRICE_W-1:0];
                end
                else
                begin
                    first_seq_reg <= pwdata;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        qty_reg     <= qty_next;
        side_reg    <= side_next;
        lvl_off_reg <= lvl_off_next;
        scan_reg    <= scan_next;
        status_reg  <= status_next;
        if (accept)
        begin
            del_reg <= mode;
            key_reg <= order_key;
            off_reg <= price_diff[TW-1:0];
            win_reg <= price_in_win;
        end
        if (state_reg == S_MOD)
        begin
            slot_idx_reg <= mod_rem;
        end
    end

    // Result item
    assign out_valid      = (state_reg == S_OUT);
    assign status         = status_reg;
    assign book_stale     = stale_reg;
    assign best_bid_price = bid_v_reg ? (base_reg + PRICE_W'(bid_off_reg)) : '0;
    assign best_ask_price = ask_v_reg ? (base_reg + PRICE_W'(ask_off_reg)) : '0;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in flight");

    a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result waits");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_CK) |-> (scan_reg <= TOP_OFF))
        else $error("level scan left the price window");
`endif

endmodule

// ----- tb/sv/sequenced_order_book_core_test.sv -----
// Self-checking testbench for the sequenced order book core.
module sequenced_order_book_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sob_pkg::*;

    localparam int SLOTS = 4096;
    localparam int TICKS = 4096;
    localparam logic [3:0] ADDR_FIRST_SEQ = 4'd0;
    localparam logic [3:0] ADDR_PRICE_BASE = 4'd8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [SEQ_W-1:0] sequence_number = '0;
    logic mode = MODE_ADD;
    logic [KEY_W-1:0] order_key = '0;
    logic [PRICE_W-1:0] order_price = '0;
    logic [QTY_W-1:0] order_quantity = '0;
    logic buy_side = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [STAT_W-1:0] status;
    logic [PRICE_W-1:0] best_bid_price, best_ask_price;
    logic book_stale;

    sequenced_order_book_core u_dut (.*);

    always #10 clk = ~clk;

    typedef struct packed {
        logic [STAT_W-1:0] st;
        logic [PRICE_W-1:0] bid;
        logic [PRICE_W-1:0] ask;
        logic stale;
    } book_result_t;

    // book mirror
    logic [SEQ_W-1:0] exp_seq;
    logic [PRICE_W-1:0] base_price;
    logic stale_mirror;
    logic slot_live [SLOTS];
    logic [KEY_W-1:0] slot_key [SLOTS];
    logic [11:0] slot_off [SLOTS];
    logic [QTY_W-1:0] slot_qty [SLOTS];
    logic slot_buy [SLOTS];
    logic [LVL_W-1:0] bid_total [TICKS];
    logic [LVL_W-1:0] ask_total [TICKS];

    book_result_t pending_results[$];
    int error_count = 0;
    int result_count = 0;
    int status_seen [6];
    // live keys for deletes
    logic [KEY_W-1:0] live_keys[$];

    function automatic logic [PRICE_W-1:0] top_bid();
        for (int i = TICKS - 1; i >= 0; i--)
            if (bid_total[i] != 0) return base_price + PRICE_W'(i);
        return '0;
    endfunction

    function automatic logic [PRICE_W-1:0] top_ask();
        for (int i = 0; i < TICKS; i++)
            if (ask_total[i] != 0) return base_price + PRICE_W'(i);
        return '0;
    endfunction

    // Apply one message to the mirror and queue its result.
    task automatic predict_book(input logic [SEQ_W-1:0] sq, input logic md,
                                input logic [KEY_W-1:0] k, input logic [PRICE_W-1:0] p,
                                input logic [QTY_W-1:0] q, input logic b);
        book_result_t r;
        int s;
        logic [PRICE_W-1:0] off;
        s = int'(k % SLOTS);
        if (sq < exp_seq) r.st = STAT_OLD;
        else if (sq > exp_seq) begin
            stale_mirror = 1'b1;
            r.st = STAT_GAP;
        end else begin
            if (md == MODE_DEL) begin
                if (!slot_live[s] || slot_key[s] != k) r.st = STAT_NOT_FOUND;
                else begin
                    if (slot_buy[s]) bid_total[slot_off[s]] -= LVL_W'(slot_qty[s]);
                    else ask_total[slot_off[s]] -= LVL_W'(slot_qty[s]);
                    slot_live[s] = 1'b0;
                    r.st = STAT_APPLIED;
                end
            end else begin
                off = p - base_price;
                if (p < base_price || off >= TICKS) r.st = STAT_OUTSIDE;
                else if (slot_live[s]) r.st = STAT_COLLISION;
                else begin
                    slot_live[s] = 1'b1;
                    slot_key[s] = k;
                    slot_off[s] = off[11:0];
                    slot_qty[s] = q;
                    slot_buy[s] = b;
                    if (b) bid_total[off] += LVL_W'(q);
                    else ask_total[off] += LVL_W'(q);
                    live_keys.push_back(k);
                    r.st = STAT_APPLIED;
                end
                if (r.st != STAT_APPLIED) stale_mirror = 1'b1;
            end
            exp_seq = exp_seq + 1;
        end
        r.bid = top_bid();
        r.ask = top_ask();
        r.stale = stale_mirror;
        pending_results.push_back(r);
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 3) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Send one message, predicting at acceptance.
    task automatic send_message(input logic [SEQ_W-1:0] sq, input logic md,
                                input logic [KEY_W-1:0] k, input logic [PRICE_W-1:0] p,
                                input logic [QTY_W-1:0] q, input logic b);
        repeat (1 + gap_len()) @(negedge clk);
        in_valid <= 1'b1;
        sequence_number <= sq;
        mode <= md;
        order_key <= k;
        order_price <= p;
        order_quantity <= q;
        buy_side <= b;
        do @(posedge clk); while (!in_ready);
        predict_book(sq, md, k, p, q, b);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (2 * TICKS + 50) @(negedge clk);
    endtask

    task automatic write_reg(input logic [3:0] a, input logic [63:0] d);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        if (a == ADDR_FIRST_SEQ) exp_seq = d;
        else base_price = d[31:0];
    endtask

    // Result checker with random back-pressure.
    initial begin
        book_result_t e;
        int hold;
        forever begin
            @(negedge clk);
            hold = gap_len();
            out_ready <= (hold == 0) || ($urandom_range(0, 1) == 1);
            @(posedge clk);
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result item");
                    error_count++;
                end else begin
                    e = pending_results.pop_front();
                    result_count++;
                    if (e.st < 6) status_seen[e.st]++;
                    if (status !== e.st) begin
                        $error("status exp %0d got %0d", e.st, status); error_count++;
                    end
                    if (best_bid_price !== e.bid) begin
                        $error("best_bid_price exp %0d got %0d", e.bid, best_bid_price);
                        error_count++;
                    end
                    if (best_ask_price !== e.ask) begin
                        $error("best_ask_price exp %0d got %0d", e.ask, best_ask_price);
                        error_count++;
                    end
                    if (book_stale !== e.stale) begin
                        $error("book_stale exp %0d got %0d", e.stale, book_stale);
                        error_count++;
                    end
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Extremes of every field and each special case.
    task automatic test_directed();
        write_reg(ADDR_PRICE_BASE, 64'd1000);
        write_reg(ADDR_FIRST_SEQ, 64'd10);
        send_message(10, MODE_ADD, 64'd5, 32'd1000, 32'd7, 1'b1);
        send_message(11, MODE_ADD, 64'd6, 32'd1000 + TICKS - 1, 32'hFFFF_FFFF, 1'b0);
        send_message(12, MODE_ADD, 64'd7, 32'd1500, 32'd0, 1'b1);
        send_message(13, MODE_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1200, 32'd3, 1'b0);
        send_message(9, MODE_ADD, 64'd8, 32'd1100, 32'd1, 1'b1);
        send_message(0, MODE_DEL, 64'd5, 32'd0, 32'd0, 1'b0);
        send_message(14, MODE_DEL, 64'd5 + SLOTS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_message(15, MODE_ADD, 64'd5, 32'd1100, 32'd2, 1'b1);
        send_message(16, MODE_ADD, 64'd5 + SLOTS, 32'd1100, 32'd2, 1'b1);
        send_message(17, MODE_ADD, 64'd9, 32'd999, 32'd2, 1'b1);
        send_message(18, MODE_ADD, 64'd9, 32'd1000 + TICKS, 32'd2, 1'b0);
        send_message(19, MODE_DEL, 64'd5, 32'd0, 32'd0, 1'b0);
        send_message(20, MODE_DEL, 64'd6, 32'd0, 32'd0, 1'b0);
        send_message(21, MODE_DEL, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 1'b1);
        send_message(25, MODE_ADD, 64'd9, 32'd1100, 32'd2, 1'b1);
        send_message(64'hFFFF_FFFF_FFFF_FFFF, MODE_DEL, 64'd7, 32'd0, 32'd0, 1'b0);
        drain();
        // rebase with live orders, then wrap the sequence
        write_reg(ADDR_PRICE_BASE, 64'hFFFF_FF00);
        write_reg(ADDR_FIRST_SEQ, 64'hFFFF_FFFF_FFFF_FFFF);
        send_message(64'hFFFF_FFFF_FFFF_FFFF, MODE_ADD, 64'd20, 32'hFFFF_FFFF, 32'd4, 1'b1);
        send_message(64'd0, MODE_ADD, 64'd21, 32'd0, 32'd4, 1'b0);
        send_message(64'd1, MODE_DEL, 64'd7, 32'd0, 32'd0, 1'b0);
        send_message(64'd2, MODE_DEL, 64'd20, 32'd0, 32'd0, 1'b0);
        drain();
    endtask

    // Mostly in-sequence traffic around the given base, with some noise.
    task automatic test_random(input int count, input logic [PRICE_W-1:0] base);
        logic [SEQ_W-1:0] sq;
        logic [KEY_W-1:0] k;
        logic [PRICE_W-1:0] p;
        logic [QTY_W-1:0] q;
        int sel;
        sq = rand64();
        write_reg(ADDR_PRICE_BASE, 64'(base));
        write_reg(ADDR_FIRST_SEQ, sq);
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            k = {$urandom, 20'd0, 12'($urandom)};
            if ($urandom_range(0, 3) == 0) k = rand64();
            p = base + $urandom_range(0, 300);
            if (sel < 5) p = $urandom;
            q = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 100);
            if (sel < 35 && live_keys.size() != 0) begin
                k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                send_message(exp_seq, MODE_DEL, k, $urandom, $urandom, 1'($urandom));
            end else if (sel < 90)
                send_message(exp_seq, MODE_ADD, k, p, q, 1'($urandom_range(0, 1)));
            else if (sel < 94)
                send_message(exp_seq - $urandom_range(1, 5), 1'($urandom), rand64(),
                             $urandom, $urandom, 1'($urandom));
            else if (sel < 96)
                send_message(exp_seq + $urandom_range(1, 5), 1'($urandom), rand64(),
                             $urandom, $urandom, 1'($urandom));
            else
                send_message(exp_seq, MODE_DEL, rand64(), $urandom, $urandom, 1'($urandom));
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
        for (int i = 0; i < TICKS; i++) begin
            bid_total[i] = '0;
            ask_total[i] = '0;
        end
        exp_seq = '0;
        base_price = '0;
        stale_mirror = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(400, 32'd0);
        test_random(400, $urandom);
        test_random(400, 32'hFFFF_FFFF - 200);
        test_random(400, 32'hFFFF_F000);
        $display("Covered %0d results: applied %0d old %0d gap %0d not-found %0d",
                 result_count, status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3]);
        $display("collisions %0d, outside window %0d, last base %0h",
                 status_seen[4], status_seen[5], base_price);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #400ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
